// ===== hdl/etx_pkg.sv =====
// Shared types, line code constants and coding functions for the 4B5B/NRZI frame transmitter.
package etx_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	localparam logic [4:0] SYM_J    = 5'b11000;
	localparam logic [4:0] SYM_K    = 5'b10001;
	localparam logic [4:0] SYM_T    = 5'b01101;
	localparam logic [4:0] SYM_R    = 5'b00111;
	localparam logic [4:0] SYM_IDLE = 5'b11111;

	localparam logic [3:0] NIB_PRE = 4'h5;
	localparam logic [3:0] NIB_SFD = 4'hd;

	// Word steps of one queue entry
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_JK   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_SFD  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_DATA = 4'd8;
	localparam logic [STEP_W-1:0] STEP_FCS0 = 4'd9;
	localparam logic [STEP_W-1:0] STEP_FCS1 = 4'd10;
	localparam logic [STEP_W-1:0] STEP_FCS2 = 4'd11;
	localparam logic [STEP_W-1:0] STEP_FCS3 = 4'd12;
	localparam logic [STEP_W-1:0] STEP_TR   = 4'd13;
	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd14;

	typedef struct packed {
		logic        first;
		logic        last;
		logic [7:0]  data;
		logic [31:0] fcs;
	} etx_entry_t;

	function automatic logic [4:0] code5(input logic [3:0] nib);
		logic [4:0] c;
		unique case (nib)
			4'h0: c = 5'h1E;
			4'h1: c = 5'h09;
			4'h2: c = 5'h14;
			4'h3: c = 5'h15;
			4'h4: c = 5'h0A;
			4'h5: c = 5'h0B;
			4'h6: c = 5'h0E;
			4'h7: c = 5'h0F;
			4'h8: c = 5'h12;
			4'h9: c = 5'h13;
			4'hA: c = 5'h16;
			4'hB: c = 5'h17;
			4'hC: c = 5'h1A;
			4'hD: c = 5'h1B;
			4'hE: c = 5'h1C;
			default: c = 5'h1D;
		endcase
		return c;
	endfunction

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/etx_front.sv =====
// Front end: accepts frame bytes, tracks frame start, folds the CRC and builds queue entries.
module etx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         frame_byte,
	input  logic               frame_last,
	input  logic               q_full,
	output logic               push,
	output etx_pkg::etx_entry_t entry
);
	import etx_pkg::*;

	logic        frame_open_q;
	logic [31:0] crc_q;
	logic [31:0] crc_base;
	logic [31:0] crc_next;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign crc_base = frame_open_q ? crc_q : CRC_ONES;
	assign crc_next = crc_byte(crc_base, frame_byte);

	always_comb begin
		entry.first = !frame_open_q;
		entry.last  = frame_last;
		entry.data  = frame_byte;
		entry.fcs   = ~crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			crc_q        <= CRC_ONES;
		end else if (push) begin
			frame_open_q <= !frame_last;
			crc_q        <= frame_last ? CRC_ONES : crc_next;
		end
	end

	a_close_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && frame_last |=> !frame_open_q && crc_q == CRC_ONES)
		else $error("frame not closed after last byte");

endmodule

// ===== hdl/etx_queue.sv =====
// Small register FIFO between the byte front end and the word sequencer.
module etx_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  etx_pkg::etx_entry_t push_data,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output etx_pkg::etx_entry_t head
);
	import etx_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	etx_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ===== hdl/etx_back.sv =====
// Back end: walks each queue entry through its words, 4B5B/NRZI codes them, output register.
module etx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  etx_pkg::etx_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [9:0]          line_bits,
	output logic                run_last,
	output logic                frame_done
);
	import etx_pkg::*;

	logic              started_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] cur_step;
	logic [STEP_W-1:0] end_step;
	logic [1:0]        fcs_idx;
	logic [7:0]        fcs_byte;
	logic              load;
	logic              at_end;
	logic [4:0]        sym_a;
	logic [4:0]        sym_b;
	logic [9:0]        ser;
	logic [9:0]        nrzi;
	logic [10:0]       lvl;
	logic              level_q;
	logic              out_valid_q;
	logic [9:0]        line_bits_q;
	logic              run_last_q;
	logic              frame_done_q;

	assign cur_step = started_q ? step_q : (head.first ? STEP_JK : STEP_DATA);
	assign end_step = head.last ? STEP_IDLE : STEP_DATA;
	assign at_end   = (cur_step == end_step);
	assign load     = head_valid && (!out_valid_q || !out_stall);
	assign pop      = load && at_end;
	assign fcs_idx  = 2'(cur_step - STEP_FCS0);
	assign fcs_byte = head.fcs[fcs_idx*8 +: 8];

	always_comb begin
		unique case (cur_step) inside
			STEP_JK: begin
				sym_a = SYM_J;
				sym_b = SYM_K;
			end
			STEP_SFD: begin
				sym_a = code5(NIB_PRE);
				sym_b = code5(NIB_SFD);
			end
			STEP_DATA: begin
				sym_a = code5(head.data[3:0]);
				sym_b = code5(head.data[7:4]);
			end
			[STEP_FCS0:STEP_FCS3]: begin
				sym_a = code5(fcs_byte[3:0]);
				sym_b = code5(fcs_byte[7:4]);
			end
			STEP_TR: begin
				sym_a = SYM_T;
				sym_b = SYM_R;
			end
			STEP_IDLE: begin
				sym_a = SYM_IDLE;
				sym_b = SYM_IDLE;
			end
			default: begin
				// preamble words
				sym_a = code5(NIB_PRE);
				sym_b = code5(NIB_PRE);
			end
		endcase
	end

	// symbols leave MSB first; a one toggles the line
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			ser[k]     = sym_a[4-k];
			ser[5 + k] = sym_b[4-k];
		end
		lvl[0] = level_q;
		for (int k = 0; k < 10; k++) begin
			lvl[k+1] = lvl[k] ^ ser[k];
			nrzi[k]  = lvl[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			step_q      <= STEP_JK;
			level_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				level_q   <= lvl[10];
				started_q <= !at_end;
				step_q    <= cur_step + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			line_bits_q  <= nrzi;
			run_last_q   <= at_end;
			frame_done_q <= (cur_step == STEP_IDLE);
		end
	end

	assign out_valid  = out_valid_q;
	assign line_bits  = line_bits_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> run_last_q)
		else $error("frame_done without run_last");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> step_q <= STEP_IDLE)
		else $error("sequencer step out of range");
	a_pop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && run_last_q)
		else $error("entry retired without final word");

endmodule

// ===== hdl/ethernet_4b5b_nrzi_frame_transmitter.sv =====
// Top level of the 4B5B/NRZI Fast Ethernet frame transmitter with CRC-32 FCS.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, frame_byte, frame_last | byte transfer into the block
//  out     | out_valid, out_stall, line_bits,           | 10-bit line word transfer out
//          | run_last, frame_done                       |
//
// The word sequencer in etx_back sets the line word rate; out_stall can hold it.
// A middle byte gives 1 word, a first byte 9 (J/K, 6 preamble words, SFD, byte), a last byte 7
// (byte, 4 FCS, T/R, IDLE/IDLE), a single-byte frame 15; bytes enter at one per cycle
// while the entry queue (QUEUE_DEPTH entries) has room.
// arst_n clears frame state, CRC preset, NRZI line level, queue and output valid.
// out_stall holds the output register; the queue absorbs bytes until it fills,
// then in_stall rises.
module ethernet_4b5b_nrzi_frame_transmitter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] frame_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [9:0] line_bits,
	output logic       run_last,
	output logic       frame_done
);
	import etx_pkg::*;

	// front-to-queue transfer
	logic       push;
	etx_entry_t push_entry;
	logic       q_full;

	// queue-to-back transfer
	logic       head_valid;
	etx_entry_t head;
	logic       pop;

	// Front: frame start detect and CRC fold, one byte per cycle while the queue is not full
	etx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_byte (frame_byte),
		.frame_last (frame_last),
		.q_full     (q_full),
		.push       (push),
		.entry      (push_entry)
	);

	// Decouples byte intake from multi-word expansion
	etx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: word sequencing, 4B5B, NRZI and the output register
	etx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_bits  (line_bits),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

endmodule
